// ----- rtl/id_base64_codec_macros.svh -----
// Assertion macros for the id_base64_codec block.
// Every use expects a clock named clock and a reset named reset in scope.
`ifndef ID_BASE64_CODEC_MACROS_SVH
`define ID_BASE64_CODEC_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define IDB64_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IDB64_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/idb64_pkg.sv -----
// Package for the id_base64_codec block: sizes, status codes, alphabet helpers.
// No dependencies.
`timescale 1ns / 1ps

package idb64_pkg;

   localparam int ID_BYTES = 21;
   localparam int ID_CHARS = (ID_BYTES * 8 + 5) / 6;
   localparam int POS_W    = $clog2(ID_CHARS);

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_AMP     = 8'h26;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_CHAR = 2'd1,
      ST_BAD_LEN  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      status_type status;
      logic       all_zero;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] sym;
   } lookup_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

   function automatic logic [11:0] low_mask(input logic [3:0] n);
      return ~(12'hFFF << n);
   endfunction

   function automatic logic [7:0] sym_to_char(input logic [5:0] s);
      logic [7:0] c;
      if (s < 6'd26) begin
         c = CH_UPPER_A + {2'b00, s};
      end else if (s < 6'd52) begin
         c = CH_LOWER_A - 8'd26 + {2'b00, s};
      end else if (s < 6'd62) begin
         c = CH_DIGIT_0 - 8'd52 + {2'b00, s};
      end else if (s == 6'd62) begin
         c = CH_UNDER;
      end else begin
         c = CH_AMP;
      end
      return c;
   endfunction

   function automatic lookup_type char_to_sym(input logic [7:0] c);
      lookup_type l;
      l.ok  = 1'b1;
      l.sym = 6'd0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         l.sym = 6'(c - CH_UPPER_A);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         l.sym = 6'(c - CH_LOWER_A + 8'd26);
      end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
         l.sym = 6'(c - CH_DIGIT_0 + 8'd52);
      end else if (c == CH_UNDER) begin
         l.sym = 6'd62;
      end else if (c == CH_AMP) begin
         l.sym = 6'd63;
      end else begin
         l.ok = 1'b0;
      end
      return l;
   endfunction

endpackage

// ----- rtl/id_base64_codec.sv -----
// id_base64_codec: identifier <-> base64 text converter, top level.
// Depends on idb64_pkg and id_base64_codec_macros.svh.
//
// Usage:
//   csr_write_en/csr_write_data set the direction (0 encode, 1 decode) and
//   abandon any identifier in progress; write only while the block is idle.
//   req_* carries one byte (encode) or one character (decode) per item, with
//   req_in_last on the final item of an identifier. rsp_* carries results;
//   rsp_out_last marks the final result of an identifier or an error result.
// Timing:
//   An accepted item lands in an input register; it is converted once the
//   result buffer can take it, and its zero, one or two results go to that
//   two-entry result buffer, whose head entry drives rsp_*. A result thus
//   passes the input register and then the result buffer before it shows.
//   Sustained rate is one item per cycle while rsp_ready stays high and
//   items give at most one result; after an item that gives two, the next
//   waits for the single result port, which drains one entry per cycle.
// Reset:
//   Synchronous, active high; clears direction to encode, empties both
//   registers and restarts the identifier. A stalled rsp_ready holds the
//   buffer; the input register takes one more item, then req_ready stays low
//   until the buffer can take that item's results.
`timescale 1ns / 1ps

`include "id_base64_codec_macros.svh"

module id_base64_codec
   import idb64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic [1:0] rsp_status,
   output logic       rsp_all_zero
);

   // input register
   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_byte_ff;
   logic             s1_last_ff;

   // conversion state
   logic             dir_ff, dir_in;
   logic [11:0]      buf_ff, buf_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             zero_ff, zero_in;
   logic             disc_ff, disc_in;

   // result buffer
   result_type       res0_ff, res0_in, res1_ff, res1_in;
   logic [1:0]       res_cnt_ff, res_cnt_in;

   logic             res_free, s1_go, rsp_fire;
   result_type       r0, r1;
   logic [1:0]       nres;

   assign rsp_fire  = rsp_valid && rsp_ready;
   assign res_free  = (res_cnt_ff == 2'd0) || ((res_cnt_ff == 2'd1) && rsp_ready);
   assign s1_go     = s1_valid_ff && res_free;
   assign req_ready = !s1_valid_ff || s1_go;

   assign rsp_valid    = (res_cnt_ff != 2'd0);
   assign rsp_out_byte = res0_ff.data;
   assign rsp_out_last = res0_ff.last;
   assign rsp_status   = res0_ff.status;
   assign rsp_all_zero = res0_ff.all_zero;

   always_comb begin : convert
      logic [POS_W-1:0] span_m1;
      logic             fin;
      lookup_type       lk;
      status_type       err;
      logic [11:0]      wb;
      logic [3:0]       wc;
      logic [7:0]       v;
      logic             z;

      span_m1 = (dir_ff == DIR_DECODE) ? POS_W'(ID_CHARS - 1) : POS_W'(ID_BYTES - 1);
      fin     = (pos_ff >= span_m1);
      lk      = char_to_sym(s1_byte_ff);
      err     = ST_OK;
      wb      = 12'd0;
      wc      = 4'd0;
      v       = 8'd0;
      z       = zero_ff;

      r0      = '{data: 8'd0, last: 1'b0, status: ST_OK, all_zero: 1'b0};
      r1      = r0;
      nres    = 2'd0;
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      zero_in = zero_ff;
      disc_in = disc_ff;

      if (dir_ff == DIR_DECODE && !lk.ok) begin
         err = ST_BAD_CHAR;
      end else if (s1_last_ff != fin) begin
         err = ST_BAD_LEN;
      end

      if (disc_ff) begin
         if (s1_last_ff) begin
            disc_in = 1'b0;
            buf_in  = 12'd0;
            cnt_in  = 4'd0;
            pos_in  = '0;
            zero_in = 1'b1;
         end
      end else if (err != ST_OK) begin
         r0      = '{data: 8'd0, last: 1'b1, status: err, all_zero: 1'b0};
         nres    = 2'd1;
         disc_in = !s1_last_ff;
         buf_in  = 12'd0;
         cnt_in  = 4'd0;
         pos_in  = '0;
         zero_in = 1'b1;
      end else begin
         if (dir_ff == DIR_ENCODE) begin
            z       = zero_ff && (s1_byte_ff == 8'd0);
            wb      = {buf_ff[3:0], rev8(s1_byte_ff)};
            wc      = cnt_ff + 4'd2;
            r0.data = sym_to_char(6'(wb >> wc));
            wb      = wb & low_mask(wc);
            nres    = 2'd1;
            if (wc >= 4'd6) begin
               wc      = wc - 4'd6;
               r1.data = sym_to_char(6'(wb >> wc));
               wb      = wb & low_mask(wc);
               nres    = 2'd2;
            end else if (fin && wc != 4'd0) begin
               r1.data = sym_to_char(6'(wb << (4'd6 - wc)));
               wc      = 4'd0;
               nres    = 2'd2;
            end
         end else begin
            wb = {buf_ff[5:0], lk.sym};
            wc = cnt_ff + 4'd6;
            if (wc >= 4'd8) begin
               wc      = wc - 4'd8;
               v       = rev8(8'(wb >> wc));
               wb      = wb & low_mask(wc);
               z       = zero_ff && (v == 8'd0);
               r0.data = v;
               nres    = 2'd1;
            end
         end

         if (fin) begin
            if (nres == 2'd2) begin
               r1.last     = 1'b1;
               r1.all_zero = z;
            end else begin
               r0.last     = 1'b1;
               r0.all_zero = z;
               nres        = 2'd1;
            end
            buf_in  = 12'd0;
            cnt_in  = 4'd0;
            pos_in  = '0;
            zero_in = 1'b1;
         end else begin
            buf_in  = wb;
            cnt_in  = wc;
            pos_in  = pos_ff + 1'b1;
            zero_in = z;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      res0_in    = res0_ff;
      res1_in    = res1_ff;
      res_cnt_in = res_cnt_ff;
      if (s1_go) begin
         res0_in    = r0;
         res1_in    = r1;
         res_cnt_in = nres;
      end else if (rsp_fire) begin
         res0_in    = res1_ff;
         res_cnt_in = res_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_in_byte;
         s1_last_ff <= req_in_last;
      end
      res0_ff <= res0_in;
      res1_ff <= res1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         res_cnt_ff  <= 2'd0;
         dir_ff      <= DIR_ENCODE;
         buf_ff      <= 12'd0;
         cnt_ff      <= 4'd0;
         pos_ff      <= '0;
         zero_ff     <= 1'b1;
         disc_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         res_cnt_ff  <= res_cnt_in;
         if (csr_write_en) begin
            dir_ff  <= dir_in;
            buf_ff  <= 12'd0;
            cnt_ff  <= 4'd0;
            pos_ff  <= '0;
            zero_ff <= 1'b1;
            disc_ff <= 1'b0;
         end else if (s1_go) begin
            buf_ff  <= buf_in;
            cnt_ff  <= cnt_in;
            pos_ff  <= pos_in;
            zero_ff <= zero_in;
            disc_ff <= disc_in;
         end
      end
   end

   assign dir_in = csr_write_en ? csr_write_data : dir_ff;

   `IDB64_ASSERT_NOW(a_res_cnt_range, 1'b1, res_cnt_ff != 2'd3, "result buffer overfilled")
   `IDB64_ASSERT_NOW(a_err_is_last, rsp_valid && rsp_status != ST_OK,
      rsp_out_last && rsp_out_byte == 8'd0, "error result not final")
   `IDB64_ASSERT_NOW(a_pos_bound, !csr_write_en && dir_in == dir_ff,
      pos_ff <= POS_W'(ID_CHARS - 1) && cnt_ff <= 4'd6 && !cnt_ff[0],
      "position or count out of range")
   `IDB64_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s1_go, s1_valid_ff, "input register lost an item")

endmodule
